FILE: src/i2cwd_pkg.sv
// Shared types and constants for the two-wire bus clock waveform divider.
`timescale 1ns / 1ps
package i2cwd_pkg;

  localparam int unsigned RATE_W = 32;
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;
  localparam logic [RATE_W-1:0] BUS_CLOCK_RESET = 32'd12000000;
  localparam logic [7:0] COUNT_LIMIT = 8'hFF;
  localparam logic [3:0] EXP_LIMIT = 4'h7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_HALVE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic take_quo;
    logic halve;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_rate;
    logic div_last;
    logic need_halve;
  } dp_status_t;

endpackage

FILE: src/i2cwd_dp.sv
// Datapath: bus clock register, restoring divider, halving stage and result register.
`timescale 1ns / 1ps
module i2cwd_dp import i2cwd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic [RATE_W-1:0] cfg_data,
  input  logic [RATE_W-1:0] target_rate_hz,
  input  dp_cmd_t           cmd,
  output dp_status_t        stat,
  output logic              done,
  output logic [6:0]        low_count,
  output logic [7:0]        high_count,
  output logic [2:0]        prescale_exponent,
  output logic [7:0]        start_stop_hold,
  output logic              status
);

  logic [RATE_W-1:0] bus_clock_hz;
  logic [RATE_W-1:0] divisor;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] quo;
  logic [STEP_W-1:0] step;
  logic [RATE_W-1:0] count;
  logic [3:0]        expo;
  logic [RATE_W:0]   trial;
  logic              err;
  logic [7:0]        cnt8;

  assign trial = {rem, quo[RATE_W-1]} - {1'b0, divisor};
  assign err = (divisor == '0) || (expo > EXP_LIMIT);
  assign cnt8 = count[7:0];

  assign stat.zero_rate = (divisor == '0);
  assign stat.div_last = (step == LAST_STEP);
  assign stat.need_halve = (count[RATE_W-1:8] != '0) && (expo <= EXP_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_clock_hz <= BUS_CLOCK_RESET;
    end else if (cfg_wr) begin
      bus_clock_hz <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor <= target_rate_hz;
      quo <= bus_clock_hz;
      rem <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + 1'b1;
      if (!trial[RATE_W]) begin
        rem <= trial[RATE_W-1:0];
        quo <= {quo[RATE_W-2:0], 1'b1};
      end else begin
        rem <= {rem[RATE_W-2:0], quo[RATE_W-1]};
        quo <= {quo[RATE_W-2:0], 1'b0};
      end
    end
    if (cmd.load) begin
      count <= '0;
      expo <= '0;
    end else if (cmd.take_quo) begin
      count <= {1'b0, quo[RATE_W-1:1]};
    end else if (cmd.halve) begin
      count <= {1'b0, count[RATE_W-1:1]};
      expo <= expo + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= err;
      if (err) begin
        low_count <= '0;
        high_count <= '0;
        prescale_exponent <= '0;
        start_stop_hold <= '0;
      end else begin
        low_count <= cnt8[7:1];
        high_count <= cnt8 - {1'b0, cnt8[7:1]};
        prescale_exponent <= expo[2:0];
        start_stop_hold <= cnt8;
      end
    end
  end

endmodule

FILE: src/i2cwd_ctrl.sv
// Controller: sequences load, division, scaling and result capture.
`timescale 1ns / 1ps
module i2cwd_ctrl import i2cwd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t stat,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (stat.zero_rate) begin
          state_next = ST_FINISH;
        end else if (stat.div_last) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: state_next = ST_HALVE;
      ST_HALVE: begin
        if (!stat.need_halve) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_DIVIDE: cmd.div_step = !stat.zero_rate;
      ST_SCALE: cmd.take_quo = 1'b1;
      ST_HALVE: cmd.halve = stat.need_halve;
      ST_FINISH: cmd.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

FILE: src/i2c_clock_waveform_divider_top.sv
// Top level of the two-wire bus clock waveform divider.
//
//   channel   signals                              direction
//   command   start, busy, target_rate_hz          in (busy out)
//   result    done, low_count, high_count,         out
//             prescale_exponent, start_stop_hold,
//             status
//   config    cfg_valid, cfg_ready, cfg_data       in (cfg_ready out)
//
// A word passes from start to done through the one-bit-a-cycle 32-step
// restoring divider followed by up to eight one-bit halvings; a zero rate
// skips both. Reset is synchronous and loads the bus clock register with
// 12000000. done is high for one cycle; busy stays high until the result
// is registered, and the receiver cannot stall.
`timescale 1ns / 1ps
module i2c_clock_waveform_divider_top import i2cwd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [RATE_W-1:0] target_rate_hz,
  output logic              done,
  output logic [6:0]        low_count,
  output logic [7:0]        high_count,
  output logic [2:0]        prescale_exponent,
  output logic [7:0]        start_stop_hold,
  output logic              status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RATE_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  i2cwd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  i2cwd_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .target_rate_hz    (target_rate_hz),
    .cmd               (cmd),
    .stat              (stat),
    .done              (done),
    .low_count         (low_count),
    .high_count        (high_count),
    .prescale_exponent (prescale_exponent),
    .start_stop_hold   (start_stop_hold),
    .status            (status)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  a_phase_sum: assert property (@(posedge clk) disable iff (rst)
    done && !status |-> (high_count + {1'b0, low_count}) == start_stop_hold)
    else $error("phase counts do not add up to hold count");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> start_stop_hold == '0 && prescale_exponent == '0)
    else $error("error result carries non-zero settings");

endmodule

FILE: dv/tb_i2c_clock_waveform_divider_top.sv
// Self-checking testbench for the two-wire bus clock waveform divider top level.
`timescale 1ns / 1ps
module tb_i2c_clock_waveform_divider_top;
  import i2cwd_pkg::*;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;
  localparam int   N_DIRECTED = 22;
  localparam int   N_PHASES   = 12;
  localparam int   PHASE_WORDS = 100;
  localparam int   SETTLE_CYCLES = 50;
  localparam int   STALL_LIMIT = 4000;

  typedef struct packed {
    logic [6:0] low_cnt;
    logic [7:0] high_cnt;
    logic [2:0] expo;
    logic [7:0] hold;
    logic       err;
  } waveform_t;

  typedef struct packed {
    logic [RATE_W-1:0] bus;
    logic [RATE_W-1:0] rate;
    logic              typed;
    waveform_t         want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [RATE_W-1:0] target_rate_hz;
  logic              done;
  logic [6:0]        low_count;
  logic [7:0]        high_count;
  logic [2:0]        prescale_exponent;
  logic [7:0]        start_stop_hold;
  logic              status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [RATE_W-1:0] cfg_data;

  waveform_t         pending_waveforms[$];
  logic [RATE_W-1:0] bus_clock_model;
  dir_row_t          dir_rows [N_DIRECTED];
  int                n_words;
  int                n_results;
  int                n_err_results;
  int                n_bus_settings;
  int                n_mismatches;
  int                stall_cycles;

  i2c_clock_waveform_divider_top u_top (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .target_rate_hz    (target_rate_hz),
    .done              (done),
    .low_count         (low_count),
    .high_count        (high_count),
    .prescale_exponent (prescale_exponent),
    .start_stop_hold   (start_stop_hold),
    .status            (status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic waveform_t derive_waveform(input logic [RATE_W-1:0] bus,
                                                input logic [RATE_W-1:0] rate);
    logic [RATE_W-1:0] cnt;
    int unsigned       e;
    waveform_t         w;
    w = '0;
    e = 0;
    if (rate == '0) begin
      w.err = STATUS_ERR;
      return w;
    end
    cnt = (bus / rate) >> 1;
    while (cnt > RATE_W'(COUNT_LIMIT) && e <= EXP_LIMIT) begin
      e++;
      cnt = cnt >> 1;
    end
    if (e > EXP_LIMIT) begin
      w.err = STATUS_ERR;
      return w;
    end
    w.low_cnt  = cnt[7:1];
    w.high_cnt = cnt[7:0] - {1'b0, cnt[7:1]};
    w.expo     = e[2:0];
    w.hold     = cnt[7:0];
    w.err      = STATUS_OK;
    return w;
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate(input logic [RATE_W-1:0] bus);
    logic [RATE_W-1:0] r;
    int unsigned       sel;
    int unsigned       n;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      r = '0;
    end else if (sel < 4) begin
      r = $urandom;
    end else if (sel < 10) begin
      r = $urandom >> $urandom_range(0, 31);
    end else begin
      n = $urandom_range(1, 70000);
      r = bus / (2 * n) + $urandom_range(0, 2);
      if (r == '0) r = 1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic run_request(input logic [RATE_W-1:0] rate, input waveform_t want);
    start          <= 1'b1;
    target_rate_hz <= rate;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_waveforms.push_back(want);
    n_words++;
  endtask

  task automatic sender_gap(input bit quiet);
    int n;
    n = 0;
    if (quiet) return;
    while ($urandom_range(0, 99) < 36) n++;
    if ($urandom_range(0, 9) == 0) n += $urandom_range(1, 45);
    if (n > 0) begin
      start          <= 1'b0;
      target_rate_hz <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_waveforms.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_bus(input logic [RATE_W-1:0] value);
    drain_results();
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid       <= 1'b0;
    cfg_data        <= $urandom;
    bus_clock_model = value;
    n_bus_settings++;
  endtask

  always @(posedge clk) begin
    waveform_t want;
    if (!rst && done) begin
      n_results++;
      if (status == STATUS_ERR) n_err_results++;
      if (pending_waveforms.size() == 0) begin
        n_mismatches++;
        $display("%0t: unexpected result, expected none, got status %0d", $time, status);
      end else begin
        want = pending_waveforms.pop_front();
        check_field("low_count", want.low_cnt, low_count);
        check_field("high_count", want.high_cnt, high_count);
        check_field("prescale_exponent", want.expo, prescale_exponent);
        check_field("start_stop_hold", want.hold, start_stop_hold);
        check_field("status", want.err, status);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [RATE_W-1:0] bus;
    logic [RATE_W-1:0] rate;
    waveform_t         want;
    bit                quiet;

    dir_rows = '{
      '{32'd12000000, 32'd0,          1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_ERR}},
      '{32'd12000000, 32'd100000,     1'b1, '{7'd30,  8'd30,  3'd0, 8'd60,  STATUS_OK}},
      '{32'd12000000, 32'd400000,     1'b1, '{7'd7,   8'd8,   3'd0, 8'd15,  STATUS_OK}},
      '{32'd12000000, 32'd1,          1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_ERR}},
      '{32'd12000000, 32'hFFFFFFFF,   1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_OK}},
      '{32'd12000000, 32'd23437,      1'b0, '0},
      '{32'd12000000, 32'd23438,      1'b0, '0},
      '{32'd12000000, 32'h80000000,   1'b0, '0},
      '{32'd12000000, 32'h55555555,   1'b0, '0},
      '{32'd12000000, 32'hAAAAAAAA,   1'b0, '0},
      '{32'd65535,    32'd1,          1'b1, '{7'd127, 8'd128, 3'd7, 8'd255, STATUS_OK}},
      '{32'd65536,    32'd1,          1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_ERR}},
      '{32'd65536,    32'd2,          1'b0, '0},
      '{32'hFFFFFFFF, 32'd1,          1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_ERR}},
      '{32'hFFFFFFFF, 32'hFFFFFFFF,   1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_OK}},
      '{32'hFFFFFFFF, 32'd8388608,    1'b1, '{7'd127, 8'd128, 3'd0, 8'd255, STATUS_OK}},
      '{32'hFFFFFFFF, 32'd0,          1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_ERR}},
      '{32'd0,        32'd5,          1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_OK}},
      '{32'd0,        32'd0,          1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_ERR}},
      '{32'd1,        32'd1,          1'b1, '{7'd0,   8'd0,   3'd0, 8'd0,   STATUS_OK}},
      '{32'd2,        32'd1,          1'b1, '{7'd0,   8'd1,   3'd0, 8'd1,   STATUS_OK}},
      '{32'd12000000, 32'd183,        1'b0, '0}
    };

    rst             = 1'b1;
    start           = 1'b0;
    target_rate_hz  = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    bus_clock_model = BUS_CLOCK_RESET;
    n_words         = 0;
    n_results       = 0;
    n_err_results   = 0;
    n_bus_settings  = 1;
    n_mismatches    = 0;
    stall_cycles    = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (dir_rows[i].bus != bus_clock_model) program_bus(dir_rows[i].bus);
      want = dir_rows[i].typed ? dir_rows[i].want
                               : derive_waveform(bus_clock_model, dir_rows[i].rate);
      run_request(dir_rows[i].rate, want);
      sender_gap(1'b0);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       bus = BUS_CLOCK_RESET;
        1:       bus = 32'd1;
        2:       bus = 32'hFFFFFFFF;
        3:       bus = 32'd48000000;
        5:       bus = 32'd66000000;
        6:       bus = $urandom >> $urandom_range(8, 24);
        7:       bus = 32'd65535;
        9:       bus = 32'd100000000;
        10:      bus = 32'h7FFFFFFF;
        11:      bus = BUS_CLOCK_RESET;
        default: bus = $urandom;
      endcase
      program_bus(bus);
      quiet = (ph == 4) || (ph == 5);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        rate = pick_rate(bus_clock_model);
        run_request(rate, derive_waveform(bus_clock_model, rate));
        sender_gap(quiet);
        if (ph == 8 && i == PHASE_WORDS / 2) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_waveforms.size() != 0) begin
      n_mismatches++;
      $display("%0t: %0d results never arrived", $time, pending_waveforms.size());
    end
    $display("Ran %0d rate requests over %0d bus clock settings, including zero and extreme rates.",
             n_words, n_bus_settings);
    $display("Checked %0d results, %0d of them flagged out of range; %0d mismatches.",
             n_results, n_err_results, n_mismatches);
    if (n_mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/i2cwd_pkg.sv
src/i2cwd_dp.sv
src/i2cwd_ctrl.sv
src/i2c_clock_waveform_divider_top.sv
dv/tb_i2c_clock_waveform_divider_top.sv
